/* rtl/ffba_pkg.sv */
// Shared types and constants for the first-fit block allocator.
// Holds status and mode codes, register indexes, reset values and word types.
// No dependencies.
`default_nettype none

package ffba_pkg;

   localparam int unsigned PAGE_BYTES   = 4096;
   localparam int unsigned HEADER_BYTES = 24;

   localparam logic [63:0] BASE_AT_RESET  = 64'hFFFF_FFFF_D000_0000;
   localparam logic [63:0] LIMIT_AT_RESET = 64'hFFFF_FFFF_F000_0000;

   localparam logic [32:0] ALIGN_MASK = 33'd15;
   localparam logic [33:0] PAGE_MASK  = 34'(PAGE_BYTES - 1);
   localparam logic [33:0] HDR_34     = 34'(HEADER_BYTES);
   localparam logic [63:0] HDR_64     = 64'(HEADER_BYTES);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NULL    = 3'd1;
   localparam logic [2:0] ST_LIMIT   = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic REG_HEAP_BASE  = 1'b0;
   localparam logic REG_HEAP_LIMIT = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] request_size;
      logic [63:0] release_address;
   } req_word_type;

   typedef struct packed {
      logic [63:0] payload_address;
      logic [2:0]  status;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] start;
      logic [32:0] size;
   } ent_type;

   typedef struct packed {
      logic        base_we;
      logic [63:0] base;
      logic [63:0] limit;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/ffba_table.sv */
// Block table storage: start/size memory and free-mark memory.
// One read and one write port each, read data registered. Uses ffba_pkg.
`default_nettype none

module ffba_table
   import ffba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 64,
   parameter int unsigned IDX_W      = 6
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_idx,
   input  wire logic             ent_we,
   input  wire logic [IDX_W-1:0] ent_idx,
   input  wire ent_type          ent_wdata,
   input  wire logic             fl_we,
   input  wire logic [IDX_W-1:0] fl_idx,
   input  wire logic             fl_wdata,
   output ent_type               rd_ent,
   output logic                  rd_free
);

   ent_type ent_mem [MAX_BLOCKS];
   logic    free_mem [MAX_BLOCKS];

   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_idx] <= ent_wdata;
      end
      if (rd_en) begin
         rd_ent <= ent_mem[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (fl_we) begin
         free_mem[fl_idx] <= fl_wdata;
      end
      if (rd_en) begin
         rd_free <= free_mem[rd_idx];
      end
   end

endmodule

`default_nettype wire

/* rtl/ffba_ctrl.sv */
// Request sequencer: scans the block table one entry per cycle through a
// shared compare unit, then, for an allocate, grows the heap when nothing
// fits. Uses ffba_pkg and ffba_table.
`default_nettype none

module ffba_ctrl
   import ffba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   output rsp_word_type      rsp_data
);

   localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_GROW = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             mode_ff, mode_in;
   logic [32:0]      want_ff, want_in;
   logic [63:0]      addr_ff, addr_in;
   logic [33:0]      bytes_ff, bytes_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [63:0]      next_ff, next_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   logic             rd_en;
   ent_type          rd_ent;
   logic             rd_free;
   logic             ent_we;
   ent_type          ent_wdata;
   logic             fl_we;
   logic [IDX_W-1:0] fl_idx;
   logic             fl_wdata;

   logic        accept;
   logic        is_null;
   logic [32:0] req_want;
   logic [33:0] total;
   logic [63:0] start_hdr;
   logic        hit;
   logic [64:0] grow_end;
   logic        grow_fail;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign is_null = (req_data.mode == MODE_ALLOC) ? (req_data.request_size == 32'd0)
                                                  : (req_data.release_address == 64'd0);
   assign req_want = ({1'b0, req_data.request_size} + ALIGN_MASK) & ~ALIGN_MASK;

   // header plus payload, rounded up to a page in bytes_in
   assign total = {1'b0, want_ff} + HDR_34;

   // shared compare unit, one table entry per cycle
   assign start_hdr = rd_ent.start + HDR_64;
   assign hit = chk_vld_ff && ((mode_ff == MODE_ALLOC) ? (rd_free && (rd_ent.size >= want_ff))
                                                       : (start_hdr == addr_ff));

   assign grow_end  = {1'b0, next_ff} + {31'd0, bytes_ff};
   assign grow_fail = grow_end[64] || (grow_end[63:0] > cfg.limit);

   assign rd_en = (state_ff == S_SCAN) && !hit && (issue_ff < count_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      want_in      = want_ff;
      addr_in      = addr_ff;
      bytes_in     = (total + PAGE_MASK) & ~PAGE_MASK;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      count_in     = count_ff;
      next_in      = next_ff;
      rsp_valid_in = 1'b0;
      rsp_word_in  = rsp_word_ff;
      ent_we       = 1'b0;
      ent_wdata.start = next_ff;
      ent_wdata.size  = 33'(bytes_ff - HDR_34);
      fl_we        = 1'b0;
      fl_idx       = chk_idx_ff;
      fl_wdata     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_data.mode;
               want_in  = req_want;
               addr_in  = req_data.release_address;
               issue_in = '0;
               if (is_null) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = '{payload_address: 64'd0, status: ST_NULL};
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               fl_we        = 1'b1;
               fl_wdata     = (mode_ff == MODE_FREE);
               rsp_valid_in = 1'b1;
               rsp_word_in.status          = ST_OK;
               rsp_word_in.payload_address = (mode_ff == MODE_ALLOC) ? start_hdr : 64'd0;
               state_in = S_IDLE;
            end else if (issue_ff < count_ff) begin
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + 1'b1;
            end else if (mode_ff == MODE_FREE) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{payload_address: 64'd0, status: ST_UNKNOWN};
               state_in     = S_IDLE;
            end else begin
               state_in = S_GROW;
            end
         end
         S_GROW: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            priority if (count_ff >= MAX_CNT) begin
               rsp_word_in = '{payload_address: 64'd0, status: ST_FULL};
            end else if (grow_fail) begin
               rsp_word_in = '{payload_address: 64'd0, status: ST_LIMIT};
            end else begin
               // append a used block at the heap top
               ent_we   = 1'b1;
               fl_we    = 1'b1;
               fl_idx   = count_ff[IDX_W-1:0];
               fl_wdata = 1'b0;
               count_in = count_ff + 1'b1;
               next_in  = grow_end[63:0];
               rsp_word_in = '{payload_address: next_ff + HDR_64, status: ST_OK};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a heap base write empties the table
      if (cfg.base_we) begin
         count_in = '0;
         next_in  = cfg.base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         count_ff     <= '0;
         next_ff      <= BASE_AT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         count_ff     <= count_in;
         next_ff      <= next_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      want_ff     <= want_in;
      addr_ff     <= addr_in;
      bytes_ff    <= bytes_in;
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   ffba_table #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .IDX_W      (IDX_W)
   ) u_table (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_idx    (issue_ff[IDX_W-1:0]),
      .ent_we    (ent_we),
      .ent_idx   (count_ff[IDX_W-1:0]),
      .ent_wdata (ent_wdata),
      .fl_we     (fl_we),
      .fl_idx    (fl_idx),
      .fl_wdata  (fl_wdata),
      .rd_ent    (rd_ent),
      .rd_free   (rd_free)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("block count past table depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept && !is_null |=> busy)
      else $error("non-null request did not start a scan");

   a_fail_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_word_ff.status != ST_OK) |-> rsp_word_ff.payload_address == 64'd0)
      else $error("failed request returned an address");

   a_grow_has_room: assert property (@(posedge clock) disable iff (reset)
      ent_we |-> (count_ff < MAX_CNT) && (state_ff == S_GROW))
      else $error("new block written without room");

   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && hit |=> !busy && rsp_valid)
      else $error("table hit did not answer");

endmodule

`default_nettype wire

/* rtl/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator: configuration registers on an
// APB-style port and the request sequencer. Uses ffba_pkg and ffba_ctrl.
//
// Usage:
//   Requests: drive req_data and raise start; the word is taken at a rising
//   edge where start is high and busy is low. mode 0 allocates request_size
//   bytes, mode 1 releases release_address.
//   Responses: rsp_valid pulses for exactly one cycle with rsp_data
//   (payload_address, status). The receiver cannot stall; it must take the
//   word in that cycle.
//   Scan: a null request answers in the cycle after it is taken and does not
//   raise busy. Otherwise the sequencer reads the block table one entry per
//   cycle through a single memory port, stopping at the first match; an
//   allocate that finds no fit then grows the heap at the heap top.
//   Configuration: heap_base at byte address 0, heap_limit at 8, 64-bit
//   data, write only while idle. Writing heap_base empties the table.
//   Reset: synchronous, active high; restores the register reset values,
//   empties the table and puts the heap top at heap_base.
`default_nettype none

module first_fit_block_allocator_top
   import ffba_pkg::*;
#(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   output rsp_word_type      rsp_data,
   input  wire logic         psel,
   input  wire logic         penable,
   input  wire logic         pwrite,
   input  wire logic [3:0]   paddr,
   input  wire logic [63:0]  pwdata,
   output logic [63:0]       prdata,
   output logic              pready
);

   logic [63:0] heap_base_ff, heap_base_in;
   logic [63:0] heap_limit_ff, heap_limit_in;
   logic        csr_we;
   logic        csr_sel;
   cfg_type     cfg;

   assign pready  = 1'b1;
   assign csr_we  = psel && penable && pwrite && pready;
   assign csr_sel = paddr[3];

   always_comb begin
      heap_base_in  = heap_base_ff;
      heap_limit_in = heap_limit_ff;
      if (csr_we) begin
         unique case (csr_sel)
            REG_HEAP_BASE:  heap_base_in  = pwdata;
            REG_HEAP_LIMIT: heap_limit_in = pwdata;
            default:        heap_base_in  = heap_base_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff  <= BASE_AT_RESET;
         heap_limit_ff <= LIMIT_AT_RESET;
      end else begin
         heap_base_ff  <= heap_base_in;
         heap_limit_ff <= heap_limit_in;
      end
   end

   assign prdata = (csr_sel == REG_HEAP_LIMIT) ? heap_limit_ff : heap_base_ff;

   assign cfg.base_we = csr_we && (csr_sel == REG_HEAP_BASE);
   assign cfg.base    = pwdata;
   assign cfg.limit   = heap_limit_ff;

   ffba_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
